// ===== hw/rtl/acbp_pkg.sv =====
package acbp_pkg;

  localparam int CODE_BYTES_DEF = 6;
  localparam int MAX_CHARS_DEF  = 11;

  localparam int CODE_W = 48;
  localparam int HDR_W  = 4;
  localparam int CHAR_W = 8;
  localparam int STAT_W = 2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_LENGTH   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADCHAR  = 2'd3;

  // code lengths in bits
  localparam logic [2:0] CL_NONE  = 3'd0;
  localparam logic [2:0] CL_DIGIT = 3'd4;
  localparam logic [2:0] CL_SHORT = 3'd6;
  localparam logic [2:0] CL_LONG  = 3'd7;

  localparam logic [CHAR_W-1:0] CH_0  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ = 8'h7A;

  localparam logic [4:0] LONG_FIRST = 5'd22;
  localparam logic [4:0] LONG_BASE  = 5'd18;
  localparam logic [3:0] SHORT_BASE = 4'd10;
  localparam logic [3:0] LONG_PFX   = 4'hF;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_word;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [2:0] len;
    logic [6:0] code;
  } char_code_t;

  function automatic char_code_t char_code(input logic [CHAR_W-1:0] c);
    char_code_t r;
    logic [4:0] idx;
    logic       letter;
    r      = '0;
    idx    = '0;
    letter = 1'b0;
    case (c) inside
      [CH_0:CH_9]: begin
        r.len  = CL_DIGIT;
        r.code = 7'(c - CH_0);
      end
      [CH_UA:CH_UZ]: begin
        letter = 1'b1;
        idx    = 5'(c - CH_UA);
      end
      [CH_LA:CH_LZ]: begin
        letter = 1'b1;
        idx    = 5'(c - CH_LA);
      end
      default: r.len = CL_NONE;
    endcase
    if (letter) begin
      if (idx >= LONG_FIRST) begin
        r.len  = CL_LONG;
        r.code = {LONG_PFX, 3'(idx - LONG_BASE)};
      end else begin
        // index/4 + 10, then index%4
        r.len  = CL_SHORT;
        r.code = {1'b0, 4'({1'b0, idx[4:2]}) + SHORT_BASE, idx[1:0]};
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/alnum_code_bit_packer_top.sv =====
// Channel  Dir  Handshake          Payload
// in_      in   in_valid/in_stall   in_item_t  (character, last_char)
// out_     out  out_valid/out_stall out_item_t (code_word, status)
//
// One item per cycle sustained unless a held result stalls a last item;
// out_valid rises once the item that carries last_char has passed the
// input register and written the result register.
// The input register feeds the coding/packing logic, which writes the
// packing state and, on the last item, the result register.
// rst_n is synchronous: it empties both registers and clears the state.
// A held result stalls only a last item; other items keep flowing.
module alnum_code_bit_packer_top
  import acbp_pkg::*;
#(
  parameter int CODE_BYTES = CODE_BYTES_DEF,
  parameter int MAX_CHARS  = MAX_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int WB    = CODE_BYTES * 8;
  localparam int PK_W  = WB - HDR_W;
  localparam int BP_W  = $clog2(PK_W + 1);
  localparam int CNT_W = $clog2(MAX_CHARS + 2);

  logic                s1_valid_r;
  in_item_t            s1_data_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [PK_W-1:0]     packed_r, packed_nxt;
  logic [BP_W-1:0]     bitpos_r, bitpos_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [STAT_W-1:0]   ferr_r, ferr_nxt;

  logic                out_free;
  logic                s1_go;
  char_code_t          cc;
  logic [BP_W:0]       fill_sum;
  logic [BP_W-1:0]     shamt;
  logic [WB-1:0]       word;
  out_item_t           res;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && (!s1_data_r.last_char || out_free);
  assign in_stall  = s1_valid_r && !s1_go;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    cc         = char_code(s1_data_r.character);
    fill_sum   = {1'b0, bitpos_r} + (BP_W + 1)'(cc.len);
    cnt_nxt    = (cnt_r < CNT_W'(MAX_CHARS + 1)) ? cnt_r + 1'b1 : cnt_r;
    packed_nxt = packed_r;
    bitpos_nxt = bitpos_r;
    ferr_nxt   = ferr_r;
    if (ferr_r == ST_OK) begin
      if (cc.len == CL_NONE) begin
        ferr_nxt = ST_BADCHAR;
      end else if (fill_sum > (BP_W + 1)'(PK_W)) begin
        ferr_nxt = ST_OVERFLOW;
      end else begin
        packed_nxt = (packed_r << cc.len) | PK_W'(cc.code);
        bitpos_nxt = fill_sum[BP_W-1:0];
      end
    end
    // left-align the code bits under the length header
    shamt = BP_W'(PK_W) - bitpos_nxt;
    word  = {HDR_W'(cnt_nxt), packed_nxt << shamt};
    if (cnt_nxt > CNT_W'(MAX_CHARS)) begin
      res.code_word = '0;
      res.status    = ST_LENGTH;
    end else begin
      res.code_word = CODE_W'(word);
      res.status    = ferr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packed_r <= '0;
      bitpos_r <= '0;
      cnt_r    <= '0;
      ferr_r   <= ST_OK;
    end else if (s1_go) begin
      if (s1_data_r.last_char) begin
        packed_r <= '0;
        bitpos_r <= '0;
        cnt_r    <= '0;
        ferr_r   <= ST_OK;
      end else begin
        packed_r <= packed_nxt;
        bitpos_r <= bitpos_nxt;
        cnt_r    <= cnt_nxt;
        ferr_r   <= ferr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_data_r.last_char) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (s1_go && s1_data_r.last_char) begin
      out_data_r <= res;
    end
  end

  a_len_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_LENGTH |-> out_data_r.code_word == '0)
    else $error("length error result carries a nonzero word");

  a_bitpos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bitpos_r <= BP_W'(PK_W))
    else $error("bit position beyond word");

  a_ferr_code: assert property (@(posedge clk) disable iff (!rst_n)
    ferr_r != ST_LENGTH)
    else $error("length error latched as first error");

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CHARS + 1))
    else $error("character count past saturation");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_data_r.last_char |=>
      out_valid_r && bitpos_r == '0 && cnt_r == '0 && ferr_r == ST_OK)
    else $error("state not cleared after last item");

endmodule

// ===== dv/alnum_code_bit_packer_checker.sv =====
`timescale 1ns / 100ps

module alnum_code_bit_packer_checker
  import acbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        words_pending
);

  localparam int WORD_BITS = CODE_BYTES_DEF * 8;
  localparam int BODY_BITS = WORD_BITS - HDR_W;

  // packing state of the string in flight
  logic [63:0]       body;
  int unsigned       body_len;
  int unsigned       n_chars;
  logic [STAT_W-1:0] sticky_err;

  out_item_t words_due[$];
  out_item_t want;

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_string();
    body       = '0;
    body_len   = 0;
    n_chars    = 0;
    sticky_err = ST_OK;
  endtask

  // returns the code length, CL_NONE for a byte that is not a digit or letter
  function automatic int unsigned char_bits(input logic [CHAR_W-1:0] c,
                                            output logic [6:0] bits);
    logic [CHAR_W-1:0] idx;
    bits = '0;
    idx  = '0;
    if (c >= CH_0 && c <= CH_9) begin
      bits = 7'(c - CH_0);
      return CL_DIGIT;
    end
    if (c >= CH_LA && c <= CH_LZ) begin
      idx = c - CH_LA;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      idx = c - CH_UA;
    end else begin
      return CL_NONE;
    end
    if (idx >= LONG_FIRST) begin
      bits = {LONG_PFX, 3'(idx - LONG_BASE)};
      return CL_LONG;
    end
    bits = {1'b0, 4'(idx / 4 + SHORT_BASE), 2'(idx % 4)};
    return CL_SHORT;
  endfunction

  task automatic take_char(input in_item_t item);
    int unsigned n;
    logic [6:0]  bits;
    logic [63:0] word;
    out_item_t   res;
    if (n_chars <= MAX_CHARS_DEF) n_chars++;
    // after the first error the word is frozen, characters are only counted
    if (sticky_err == ST_OK) begin
      n = char_bits(item.character, bits);
      if (n == CL_NONE) begin
        sticky_err = ST_BADCHAR;
      end else if (HDR_W + body_len + n > WORD_BITS) begin
        sticky_err = ST_OVERFLOW;
      end else begin
        body     = (body << n) | 64'(bits);
        body_len += n;
      end
    end
    if (item.last_char) begin
      if (n_chars > MAX_CHARS_DEF) begin
        res.code_word = '0;
        res.status    = ST_LENGTH;
      end else begin
        word          = (64'(n_chars) << BODY_BITS) | (body << (BODY_BITS - body_len));
        res.code_word = word[CODE_W-1:0];
        res.status    = sticky_err;
      end
      words_due.push_back(res);
      clear_string();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_string();
      words_due.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          report($sformatf("unexpected result: code_word %h status %0d",
                           out_data.code_word, out_data.status));
        end else begin
          want = words_due.pop_front();
          if (out_data.code_word !== want.code_word)
            report($sformatf("code_word %h, expected %h",
                             out_data.code_word, want.code_word));
          if (out_data.status !== want.status)
            report($sformatf("status %0d, expected %0d", out_data.status, want.status));
        end
      end
      if (in_valid && !in_stall) take_char(in_data);
    end
    words_pending <= words_due.size();
  end

endmodule

// ===== dv/alnum_code_bit_packer_top_tb.sv =====
`timescale 1ns / 100ps

module alnum_code_bit_packer_top_tb;
  import acbp_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int          fail_count;
  int          words_pending;
  int unsigned chars_sent;
  int unsigned words_taken;
  bit          quiet;
  bit          held;

  alnum_code_bit_packer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  alnum_code_bit_packer_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .words_pending(words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[alnum_code_bit_packer_top] ERROR");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{character: c, last_char: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) send_char(t[i], i == t.len() - 1);
  endtask

  function automatic logic [CHAR_W-1:0] any_alnum();
    case ($urandom_range(0, 2))
      0:       return CH_0 + 8'($urandom_range(0, 9));
      1:       return CH_UA + 8'($urandom_range(0, 25));
      default: return CH_LA + 8'($urandom_range(0, 25));
    endcase
  endfunction

  task automatic send_random_string();
    int unsigned      kind;
    int unsigned      len;
    logic [CHAR_W-1:0] c;
    kind  = $urandom_range(0, 9);
    len   = (kind == 0) ? $urandom_range(MAX_CHARS_DEF + 1, 15)
                        : $urandom_range(1, MAX_CHARS_DEF);
    quiet = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < len; i++) begin
      if (kind >= 1 && kind <= 3) begin
        // digits only: long ones fill the word exactly
        c = CH_0 + 8'($urandom_range(0, 9));
      end else if (kind >= 4 && kind <= 7) begin
        c = any_alnum();
      end else begin
        c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : any_alnum();
      end
      send_char(c, i == len - 1);
    end
  endtask

  // result side: random pause per item, one long hold-off to back up the block
  initial begin
    int unsigned pause;
    out_stall   = 1'b0;
    words_taken = 0;
    held        = 1'b0;
    wait (rst_n);
    forever begin
      pause = quiet ? 0 : $urandom_range(0, 7);
      if (words_taken == 40 && !held) begin
        pause = 300;
        held  = 1'b1;
      end
      if (pause > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (pause - 1) @(negedge clk);
        @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      words_taken++;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    quiet      = 1'b0;
    chars_sent = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    send_text("0aVWz9");           // digit and letter code extremes
    send_text("\001z");            // bad character first, rest ignored
    send_text("WXYZwxy");          // seventh long letter overflows
    send_text("0123\3774567890");  // too long wins over the bad character

    while (chars_sent < 1150) send_random_string();
    in_valid = 1'b0;

    while (words_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("[alnum_code_bit_packer_top] OK");
    end else begin
      $display("[alnum_code_bit_packer_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/acbp_pkg.sv
hw/rtl/alnum_code_bit_packer_top.sv
dv/alnum_code_bit_packer_checker.sv
dv/alnum_code_bit_packer_top_tb.sv
